// ----- rtl/ufem_pkg.sv -----
// shared types, constants and the control store of the union-find merger
package ufem_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 32;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// item kinds on the input side
	localparam logic REQ_INIT = 1'b0;
	localparam logic REQ_EDGE = 1'b1;

	// program steps
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_A_WRD   = 4'd1,
		ST_A_WCMP  = 4'd2,
		ST_A_CCHK  = 4'd3,
		ST_A_CWR   = 4'd4,
		ST_A_END   = 4'd5,
		ST_B_WRD   = 4'd6,
		ST_B_WCMP  = 4'd7,
		ST_B_CCHK  = 4'd8,
		ST_B_CWR   = 4'd9,
		ST_LINK    = 4'd10,
		ST_CLR     = 4'd11,
		ST_RST_CLR = 4'd12,
		ST_DONE    = 4'd13
	} step_t;

	// parent table access of one step
	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_RD_ROOT,
		MEM_RD_CUR,
		MEM_WR_CUR,
		MEM_WR_SWEEP,
		MEM_WR_LINK
	} mem_op_t;

	// jump conditions: true goes to target, false goes to nxt; dispatch branches on the accepted item
	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_DISPATCH,
		CND_NOT_ROOT,
		CND_CUR_ROOT,
		CND_SWEEP_MORE,
		CND_OUT_BUSY
	} cond_t;

	// control word fields that drive the datapath
	typedef struct packed {
		logic    take;
		mem_op_t mem_op;
		logic    hop;
		logic    adv;
		logic    ld_b;
		logic    emit;
	} ctl_t;

	typedef struct packed {
		ctl_t  ctl;
		cond_t cond;
		step_t target;
		step_t nxt;
	} ucode_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic in_fire;
		logic is_init;
		logic bad;
		logic not_root;
		logic cur_root;
		logic sweep_more;
		logic out_busy;
	} sts_t;

	function automatic ucode_t uw(logic take, mem_op_t mem_op, logic hop, logic adv,
			logic ld_b, logic emit, cond_t cond, step_t target, step_t nxt);
		ucode_t w;
		w.ctl.take   = take;
		w.ctl.mem_op = mem_op;
		w.ctl.hop    = hop;
		w.ctl.adv    = adv;
		w.ctl.ld_b   = ld_b;
		w.ctl.emit   = emit;
		w.cond       = cond;
		w.target     = target;
		w.nxt        = nxt;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode(step_t s);
		ucode_t w;
		case (s)
			ST_IDLE:    w = uw(1'b1, MEM_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_DISPATCH, ST_IDLE, ST_IDLE);
			ST_A_WRD:   w = uw(1'b0, MEM_RD_ROOT, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_ALWAYS, ST_A_WCMP, ST_A_WCMP);
			ST_A_WCMP:  w = uw(1'b0, MEM_NONE, 1'b1, 1'b0, 1'b0, 1'b0,
				CND_NOT_ROOT, ST_A_WRD, ST_A_CCHK);
			ST_A_CCHK:  w = uw(1'b0, MEM_RD_CUR, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_CUR_ROOT, ST_A_END, ST_A_CWR);
			ST_A_CWR:   w = uw(1'b0, MEM_WR_CUR, 1'b0, 1'b1, 1'b0, 1'b0,
				CND_ALWAYS, ST_A_CCHK, ST_A_CCHK);
			ST_A_END:   w = uw(1'b0, MEM_NONE, 1'b0, 1'b0, 1'b1, 1'b0,
				CND_ALWAYS, ST_B_WRD, ST_B_WRD);
			ST_B_WRD:   w = uw(1'b0, MEM_RD_ROOT, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_ALWAYS, ST_B_WCMP, ST_B_WCMP);
			ST_B_WCMP:  w = uw(1'b0, MEM_NONE, 1'b1, 1'b0, 1'b0, 1'b0,
				CND_NOT_ROOT, ST_B_WRD, ST_B_CCHK);
			ST_B_CCHK:  w = uw(1'b0, MEM_RD_CUR, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_CUR_ROOT, ST_LINK, ST_B_CWR);
			ST_B_CWR:   w = uw(1'b0, MEM_WR_CUR, 1'b0, 1'b1, 1'b0, 1'b0,
				CND_ALWAYS, ST_B_CCHK, ST_B_CCHK);
			ST_LINK:    w = uw(1'b0, MEM_WR_LINK, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_ALWAYS, ST_DONE, ST_DONE);
			ST_CLR:     w = uw(1'b0, MEM_WR_SWEEP, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_SWEEP_MORE, ST_CLR, ST_DONE);
			ST_RST_CLR: w = uw(1'b0, MEM_WR_SWEEP, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_SWEEP_MORE, ST_RST_CLR, ST_IDLE);
			ST_DONE:    w = uw(1'b0, MEM_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
				CND_OUT_BUSY, ST_DONE, ST_IDLE);
			default:    w = uw(1'b0, MEM_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
				CND_ALWAYS, ST_IDLE, ST_IDLE);
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/ufem_seq.sv -----
// step counter and control store readout of the union-find merger
module ufem_seq
	import ufem_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	step_t  pc_q;
	step_t  pc_d;
	ucode_t word;
	logic   hit;

	assign word = ucode(pc_q);
	assign ctl  = word.ctl;

	// condition select
	always_comb begin
		case (word.cond)
			CND_ALWAYS:     hit = 1'b1;
			CND_NOT_ROOT:   hit = sts.not_root;
			CND_CUR_ROOT:   hit = sts.cur_root;
			CND_SWEEP_MORE: hit = sts.sweep_more;
			CND_OUT_BUSY:   hit = sts.out_busy;
			default:        hit = 1'b0;
		endcase
	end

	// next step, with the multiway branch on an accepted item
	always_comb begin
		if (word.cond == CND_DISPATCH) begin
			if (!sts.in_fire) begin
				pc_d = ST_IDLE;
			end else if (sts.is_init) begin
				pc_d = ST_CLR;
			end else if (sts.bad) begin
				pc_d = ST_DONE;
			end else begin
				pc_d = ST_A_WRD;
			end
		end else begin
			pc_d = hit ? word.target : word.nxt;
		end
	end

	// step counter, starts in the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_RST_CLR;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- rtl/ufem_dp.sv -----
// datapath of the union-find merger: parent table, walk registers, result register
module ufem_dp
	import ufem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  cnt_t             lim,
	output sts_t             sts,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser
);

	node_t            parent_mem [MAX_NODES];
	node_t            rdata_q;
	node_t            a_q;
	node_t            b_q;
	node_t            root_q;
	node_t            cur_q;
	node_t            ra_q;
	node_t            idx_q;
	cnt_t             total_q;
	logic             err_q;
	logic             joined_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tuser_q;

	node_t in_first;
	node_t in_second;
	logic  in_fire;
	logic  range_err;
	logic  out_busy;
	logic  link_go;
	logic  mem_we;
	node_t mem_waddr;
	node_t mem_wdata;
	logic  mem_re;
	node_t mem_raddr;

	assign in_first  = s_tdata[NODE_W-1:0];
	assign in_second = s_tdata[2*NODE_W-1:NODE_W];
	assign s_tready  = ctl.take;
	assign in_fire   = s_tvalid && ctl.take;
	assign range_err = ({1'b0, in_first} >= lim) || ({1'b0, in_second} >= lim);
	assign out_busy  = m_tvalid_q && !m_tready;
	assign link_go   = (ctl.mem_op == MEM_WR_LINK) && (ra_q != root_q);

	// status back to the sequencer
	assign sts.in_fire    = in_fire;
	assign sts.is_init    = (s_tuser == REQ_INIT);
	assign sts.bad        = range_err || (total_q <= cnt_t'(1));
	assign sts.not_root   = (rdata_q != root_q);
	assign sts.cur_root   = (cur_q == root_q);
	assign sts.sweep_more = (idx_q != '1);
	assign sts.out_busy   = out_busy;

	// table port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = root_q;
		mem_re    = 1'b0;
		mem_raddr = root_q;
		case (ctl.mem_op)
			MEM_RD_ROOT: begin
				mem_re = 1'b1;
			end
			MEM_RD_CUR: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q;
			end
			MEM_WR_CUR: begin
				mem_we = 1'b1;
			end
			MEM_WR_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = idx_q;
			end
			MEM_WR_LINK: begin
				mem_we    = link_go;
				mem_waddr = ra_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// parent table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			parent_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= parent_mem[mem_raddr];
		end
	end

	// walk registers and item fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			root_q   <= in_first;
			cur_q    <= in_first;
			a_q      <= (s_tuser == REQ_INIT) ? '0 : in_first;
			b_q      <= (s_tuser == REQ_INIT) ? '0 : in_second;
			err_q    <= (s_tuser == REQ_EDGE) && range_err;
		end
		if (ctl.hop) begin
			root_q <= rdata_q;
		end
		if (ctl.adv) begin
			cur_q <= rdata_q;
		end
		if (ctl.ld_b) begin
			ra_q   <= root_q;
			root_q <= b_q;
			cur_q  <= b_q;
		end
	end

	// set count, sweep index and join flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= cnt_t'(MAX_NODES);
			idx_q    <= '0;
			joined_q <= 1'b0;
		end else begin
			if (in_fire) begin
				joined_q <= 1'b0;
				if (s_tuser == REQ_INIT) begin
					total_q <= lim;
				end
			end
			if (ctl.mem_op == MEM_WR_SWEEP) begin
				idx_q <= idx_q + node_t'(1);
			end
			if (link_go) begin
				total_q  <= total_q - cnt_t'(1);
				joined_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.emit && !out_busy) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && !out_busy) begin
			m_tdata_q <= {b_q, a_q, total_q, joined_q};
			m_tuser_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- rtl/union_find_edge_merger_core.sv -----
// top level of the union-find merger: node count register, sequencer and datapath
//
// Union-find engine for building a spanning tree from edges that arrive sorted by
// weight. An init item (tuser 0) points every one of the 1024 parent entries at
// itself and loads the set count with min(node_count, 1024), clearing
// one table entry per cycle through the single write port. An edge item (tuser 1)
// finds both roots, points every node on the walked paths straight at its root,
// and links the first root under the second when they differ. The walks loop on
// reads of the parent table (address out, registered data back); an edge with an
// endpoint out of range, or offered while one set remains, skips the walks and
// goes straight to its result. Items are handled one at a time. After reset the
// block runs a pass that clears the parent table and accepts no item until it is
// done; node_count may be written during that pass. Write node_count only while
// the block is idle.
module union_find_edge_merger_core
	import ufem_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration: node_count [10:0]
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// first_node [9:0], second_node [19:10], zero [23:20]
	input  logic [IN_W-1:0]  s_tdata,
	// req_type [0]
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// joined [0], set_count [11:1], edge_first [21:12], edge_second [31:22]
	output logic [OUT_W-1:0] m_tdata,
	// error [0]
	output logic             m_tuser
);

	cnt_t node_count_q;
	cnt_t lim;
	ctl_t ctl;
	sts_t sts;

	// node count register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= cnt_t'(MAX_NODES);
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	// nodes in use, capped at the table size
	assign lim = (node_count_q > cnt_t'(MAX_NODES)) ? cnt_t'(MAX_NODES) : node_count_q;

	ufem_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	ufem_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.lim      (lim),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTHESIS
	// one item at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item still in work");

	// a joined edge never reports an error
	a_join_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> !m_tuser)
		else $error("joined item flagged as error");

	// set count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:1] <= cnt_t'(MAX_NODES)))
		else $error("set count above table size");
`endif

endmodule

// ----- test/tb.sv -----
// self-checking testbench for union_find_edge_merger_core against a union-find predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ufem_pkg::*;

	// the run bound leaves room for long chains and stalls
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int IDLE_SETTLE  = 24;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 78;
	localparam int WINDOW_NODES = 24;

	typedef struct {
		logic  kind;
		node_t first;
		node_t second;
	} edge_req_t;

	typedef struct {
		logic  joined;
		logic  err;
		cnt_t  set_count;
		node_t first;
		node_t second;
	} merge_result_t;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;
	logic              s_tuser   = 1'b0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;

	// predictor state
	node_t         parent_tbl [MAX_NODES];
	cnt_t          set_total;
	cnt_t          node_count_reg;

	edge_req_t     pending_reqs [$];
	merge_result_t expected_merges [$];
	edge_req_t     next_req;

	bit            no_idle = 1'b0;
	int            send_gap = 0;
	int            ready_hold = 0;
	int            rx_count = 0;
	int            cycle_count = 0;
	int            mismatches = 0;
	int            results_seen = 0;
	int            n_items = 0;
	int            n_inits = 0;
	int            n_joins = 0;
	int            n_range_errors = 0;
	int            n_settings = 0;

	union_find_edge_merger_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_parents();
		for (int i = 0; i < MAX_NODES; i++)
			parent_tbl[i] = node_t'(i);
	endfunction

	// walk to the root, then point every node of the path straight at it
	function automatic node_t find_root_compress(input node_t x);
		node_t root;
		node_t cur;
		node_t nxt;
		int    steps;
		root  = x;
		steps = 0;
		while (parent_tbl[root] != root && steps < MAX_NODES) begin
			root = parent_tbl[root];
			steps++;
		end
		cur   = x;
		steps = 0;
		while (cur != root && steps < MAX_NODES) begin
			nxt = parent_tbl[cur];
			parent_tbl[cur] = root;
			cur = nxt;
			steps++;
		end
		return root;
	endfunction

	// expected result of one accepted item
	function automatic void predict_merge(input logic kind, input node_t a, input node_t b);
		merge_result_t r;
		int unsigned   lim;
		node_t         ra;
		node_t         rb;
		lim      = (node_count_reg > MAX_NODES) ? MAX_NODES : node_count_reg;
		r.joined = 1'b0;
		r.err    = 1'b0;
		r.first  = a;
		r.second = b;
		n_items++;
		if (kind == REQ_INIT) begin
			clear_parents();
			set_total = cnt_t'(lim);
			r.first   = '0;
			r.second  = '0;
			n_inits++;
		end else if (a >= lim || b >= lim) begin
			r.err = 1'b1;
			n_range_errors++;
		end else if (set_total > 1) begin
			ra = find_root_compress(a);
			rb = find_root_compress(b);
			if (ra != rb) begin
				parent_tbl[ra] = rb;
				set_total      = set_total - cnt_t'(1);
				r.joined       = 1'b1;
				n_joins++;
			end
		end
		r.set_count = set_total;
		expected_merges.insert(expected_merges.size(), r);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	function automatic void push_req(input logic kind, input int a, input int b);
		edge_req_t q;
		q.kind   = kind;
		q.first  = node_t'(a);
		q.second = node_t'(b);
		pending_reqs.insert(pending_reqs.size(), q);
	endfunction

	// wait until no item is queued, offered or outstanding, then let the block settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_merges.size() != 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_node_count(input cnt_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		node_count_reg = value;
		n_settings++;
		cfg_valid <= 1'b0;
	endtask

	// input driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			predict_merge(s_tuser, s_tdata[NODE_W-1:0], s_tdata[2*NODE_W-1:NODE_W]);
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				next_req = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_req.kind;
				s_tdata  <= {{(IN_W - 2*NODE_W){1'b0}}, next_req.second, next_req.first};
				send_gap <= no_idle ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		merge_result_t e;
		logic          got_joined;
		cnt_t          got_count;
		node_t         got_first;
		node_t         got_second;
		if (m_tvalid && m_tready) begin
			results_seen++;
			got_joined = m_tdata[0];
			got_count  = m_tdata[CNT_W:1];
			got_first  = m_tdata[CNT_W+NODE_W:CNT_W+1];
			got_second = m_tdata[CNT_W+2*NODE_W:CNT_W+NODE_W+1];
			if (expected_merges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with nothing pending: joined %0b err %0b count %0d edge %0d-%0d",
						$time, got_joined, m_tuser, got_count, got_first, got_second);
			end else begin
				e = expected_merges.pop_front();
				if (got_joined !== e.joined || m_tuser !== e.err ||
						got_count !== e.set_count || got_first !== e.first ||
						got_second !== e.second) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] result %0d: expected joined %0b err %0b count %0d edge %0d-%0d,",
							$time, results_seen, e.joined, e.err, e.set_count, e.first, e.second);
						$display("    got joined %0b err %0b count %0d edge %0d-%0d",
							got_joined, m_tuser, got_count, got_first, got_second);
					end
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			rx_count <= rx_count + 1;
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if (m_tvalid && m_tready && (rx_count == 39 || rx_count == 699)) begin
			// long back-pressure so the block backs up and stalls its input
			ready_hold <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			ready_hold <= pick_gap();
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, expected_merges.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned count_plan [14];
		int    r;
		int    lim;
		int    window;
		int    a;
		int    b;

		count_plan = '{16, 1024, 8, 300, 2047, 1, 64, 1025, 32, 0, 128, 5, 1024, 3};
		node_count_reg = cnt_t'(MAX_NODES);
		set_total      = cnt_t'(MAX_NODES);
		clear_parents();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default count, joins across the full index range and same-set edges
		push_req(REQ_EDGE, 0, 1023);
		push_req(REQ_EDGE, 1023, 0);
		push_req(REQ_EDGE, 1023, 1023);
		push_req(REQ_EDGE, 512, 511);
		push_req(REQ_INIT, $urandom_range(0, 1023), $urandom_range(0, 1023));
		wait_idle();

		// single node: one set left from the start, anything else out of range
		write_node_count(cnt_t'(1));
		push_req(REQ_INIT, 1023, 1023);
		push_req(REQ_EDGE, 0, 0);
		push_req(REQ_EDGE, 0, 1);
		push_req(REQ_EDGE, 1023, 1023);
		wait_idle();

		// zero nodes: every edge is out of range, init loads a count of zero
		write_node_count(cnt_t'(0));
		push_req(REQ_EDGE, 0, 0);
		push_req(REQ_INIT, 0, 0);
		push_req(REQ_EDGE, 0, 0);
		wait_idle();

		// two nodes: one join, then a single set remains
		write_node_count(cnt_t'(2));
		push_req(REQ_INIT, 0, 0);
		push_req(REQ_EDGE, 1, 0);
		push_req(REQ_EDGE, 0, 1);
		push_req(REQ_EDGE, 0, 2);
		wait_idle();

		// count above the table size, changed without init, then joins with compression
		write_node_count(cnt_t'(2047));
		push_req(REQ_EDGE, 1000, 3);
		push_req(REQ_INIT, 0, 0);
		push_req(REQ_EDGE, 3, 1000);
		push_req(REQ_EDGE, 1000, 5);
		push_req(REQ_EDGE, 5, 3);

		// random phases over a range of node counts
		for (int p = 0; p < $size(count_plan); p++) begin
			wait_idle();
			write_node_count(cnt_t'(count_plan[p]));
			lim     = (count_plan[p] > MAX_NODES) ? MAX_NODES : count_plan[p];
			window  = (lim < WINDOW_NODES) ? lim : WINDOW_NODES;
			no_idle = ($urandom_range(0, 3) == 0);
			// now and then keep the old sets so the new count applies without init
			if ($urandom_range(0, 4) != 0)
				push_req(REQ_INIT, $urandom_range(0, 1023), $urandom_range(0, 1023));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					push_req(REQ_INIT, $urandom_range(0, 1023), $urandom_range(0, 1023));
				end else if (r < 14 || lim == 0) begin
					// noise over the whole index range, one endpoint sometimes valid
					a = $urandom_range(0, 1023);
					b = (lim != 0 && r[0]) ? $urandom_range(0, lim - 1)
						: $urandom_range(0, 1023);
					if (r[1])
						push_req(REQ_EDGE, a, b);
					else
						push_req(REQ_EDGE, b, a);
				end else if (r < 60) begin
					// a narrow window builds deep trees and many joins
					a = $urandom_range(0, window - 1);
					b = $urandom_range(0, window - 1);
					push_req(REQ_EDGE, a, b);
				end else begin
					a = $urandom_range(0, lim - 1);
					b = $urandom_range(0, lim - 1);
					push_req(REQ_EDGE, a, b);
				end
			end
		end
		wait_idle();

		$display("covered %0d items: %0d inits, %0d edges, %0d joins, %0d out-of-range edges",
			n_items, n_inits, n_items - n_inits, n_joins, n_range_errors);
		$display("%0d node count settings, %0d results checked", n_settings, results_seen);
		if (mismatches == 0 && expected_merges.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ufem_pkg.sv
rtl/ufem_seq.sv
rtl/ufem_dp.sv
rtl/union_find_edge_merger_core.sv
test/tb.sv
